/* sv/htfp_pkg.sv */
// types and constants shared by the touch frame parser modules
// no dependencies

package htfp_pkg;

   localparam logic [7:0] HDR_FIRST      = 8'hA5;
   localparam logic [7:0] HDR_SECOND     = 8'h5A;
   localparam logic [7:0] CMD_READ_REPLY = 8'h83;

   // smallest length that carries address, word count and one key word
   localparam logic [7:0] MIN_KEY_LEN    = 8'd6;
   // smallest length that carries a second word
   localparam logic [7:0] MIN_TWO_LEN    = 8'd8;
   // bytes before the length-counted part: two header bytes and the length
   localparam int         HDR_BYTES      = 3;

   // byte positions inside a frame
   localparam int POS_CMD     = 3;
   localparam int POS_ADDR_HI = 4;
   localparam int POS_ADDR_LO = 5;
   localparam int POS_NWORDS  = 6;
   localparam int POS_KEY_HI  = 7;
   localparam int POS_KEY_LO  = 8;
   localparam int POS_MINS_HI = 9;
   localparam int POS_MINS_LO = 10;

   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_COUNT  = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_BUTTON_KEY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOURS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MINUTES     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SET_LOGIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_MODE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOGIN       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PRECHARGE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_APPLY       = 3'd7;

   localparam logic EV_BUTTON = 1'b0;
   localparam logic EV_KEY    = 1'b1;

   // one decodable read-reply frame, as handed from parser to event stage
   typedef struct packed {
      logic [15:0] addr;
      logic [15:0] key;
      logic [15:0] mins;
      logic        two_words;
   } frame_rec_type;

   // one result word
   typedef struct packed {
      logic        kind;
      logic [15:0] addr;
      logic [15:0] value;
      logic        inval;
      logic        last;
   } event_type;

endpackage

/* sv/hmi_touch_frame_parser.sv */
// top level of the touch frame parser: parser, record queue, event stage,
// result queue; depends on htfp_pkg, htfp_front, htfp_back, htfp_fifo
//
// usage
//   input side is a queue: drive req_rx_byte and raise push; the byte is
//   taken on a clock edge with push high and full low. one byte per cycle
//   is sustained as long as results drain.
//   result side is a queue: while empty is low the oldest event word sits
//   on the rsp_ ports; raise pop to take it. a byte that completes a
//   frame gives zero, one or two words; last_of_run marks the final one.
//   path: the record queue is written on the edge that takes a frame's
//   last byte; the event stage then moves the frame's words to the result
//   queue, a second word after the first. throughput is set by the event
//   stage, one word per cycle while the result queue has room; a decodable
//   frame has at least nine bytes, so a byte stream never outruns it.
//   stall: if pop stays low the result queue fills, the event stage holds
//   its record, the record queue fills and full rises.
//   csr port: write the eight address registers with csr_wr_en only while
//   the block is idle; no read-back.
//   reset (synchronous, high) clears the parser, the queues and the
//   address registers; full and empty are valid the cycle after.

module hmi_touch_frame_parser #(
   parameter int MAX_FRAME_LEN = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // byte input
   input  logic                            push,
   output logic                            full,
   input  logic [7:0]                      req_rx_byte,
   // event output
   output logic                            empty,
   input  logic                            pop,
   output logic                            rsp_event_kind,
   output logic [15:0]                     rsp_event_addr,
   output logic [15:0]                     rsp_key_value,
   output logic                            rsp_invalidate_page,
   output logic                            rsp_last_of_run,
   // address registers
   input  logic                            csr_wr_en,
   input  logic [htfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [htfp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import htfp_pkg::*;

   localparam int REC_W = $bits(frame_rec_type);
   localparam int EV_W  = $bits(event_type);

   logic          byte_take;
   logic          rec_push;
   frame_rec_type rec_in_q, rec_head;
   logic          mid_full, mid_empty, rec_pop;
   logic          ev_push, ev_full;
   event_type     ev_in_q, ev_head;
   logic [REC_W-1:0] rec_head_bits;
   logic [EV_W-1:0]  ev_head_bits;

   // a byte is taken whenever the record queue has room
   assign full      = mid_full;
   assign byte_take = push && !mid_full;

   htfp_front #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_take),
      .rx_byte    (req_rx_byte),
      .rec_push   (rec_push),
      .rec        (rec_in_q)
   );

   // decouples parsing from event generation
   htfp_fifo #(
      .WIDTH (REC_W),
      .DEPTH (MID_DEPTH)
   ) u_rec_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec_in_q),
      .full      (mid_full),
      .pop       (rec_pop),
      .pop_data  (rec_head_bits),
      .empty     (mid_empty)
   );

   assign rec_head = frame_rec_type'(rec_head_bits);

   htfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rec_valid (!mid_empty),
      .rec       (rec_head),
      .rec_pop   (rec_pop),
      .ev_full   (ev_full),
      .ev_push   (ev_push),
      .ev        (ev_in_q)
   );

   // result words wait here for the consumer
   htfp_fifo #(
      .WIDTH (EV_W),
      .DEPTH (OUT_DEPTH)
   ) u_ev_q (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_in_q),
      .full      (ev_full),
      .pop       (pop),
      .pop_data  (ev_head_bits),
      .empty     (empty)
   );

   assign ev_head             = event_type'(ev_head_bits);
   assign rsp_event_kind      = ev_head.kind;
   assign rsp_event_addr      = ev_head.addr;
   assign rsp_key_value       = ev_head.value;
   assign rsp_invalidate_page = ev_head.inval;
   assign rsp_last_of_run     = ev_head.last;

`ifndef SYNTHESIS
   // action button words always close their run and drop the page
   a_button_word : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_event_kind == EV_BUTTON) |->
         (rsp_invalidate_page && rsp_last_of_run))
      else $error("button word without invalidate or last flag");

   // only hours/minutes key words keep the page
   a_keep_page_is_key : assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_invalidate_page) |-> (rsp_event_kind == EV_KEY))
      else $error("page kept on a button word");

   // result queue comes out of reset empty
   a_reset_empty : assert property (@(posedge clock)
      reset |=> empty)
      else $error("result queue not empty after reset");

   // the event stage only pops a record that is there
   a_rec_pop_valid : assert property (@(posedge clock) disable iff (reset)
      rec_pop |-> !mid_empty)
      else $error("record popped from empty queue");
`endif

endmodule

/* sv/htfp_fifo.sv */
// small first-in first-out queue of flat words
// no dependencies

module htfp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/htfp_front.sv */
// byte parser: header hunt, length check, field capture, frame classify
// depends on htfp_pkg

module htfp_front #(
   parameter int MAX_FRAME_LEN = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   input  logic [7:0]             rx_byte,
   output logic                   rec_push,
   output htfp_pkg::frame_rec_type rec
);
   import htfp_pkg::*;

   localparam int IW = $clog2(MAX_FRAME_LEN + 1);

   logic [IW-1:0] idx_ff, idx_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [15:0]   addr_ff, addr_in;
   logic [7:0]    nw_ff, nw_in;
   logic [15:0]   key_ff, key_in;
   logic [15:0]   mins_ff, mins_in;
   logic [9:0]    idx_next_w;
   logic          frame_done;
   logic          decodable;

   always_comb begin
      idx_in     = idx_ff;
      len_in     = len_ff;
      cmd_in     = cmd_ff;
      addr_in    = addr_ff;
      nw_in      = nw_ff;
      key_in     = key_ff;
      mins_in    = mins_ff;
      frame_done = 1'b0;
      idx_next_w = 10'(idx_ff) + 10'd1;

      if (byte_valid) begin
         if (idx_ff == IW'(0)) begin
            if (rx_byte == HDR_FIRST) begin
               idx_in = IW'(1);
            end
         end else if (idx_ff == IW'(1)) begin
            if (rx_byte == HDR_SECOND) begin
               idx_in = IW'(2);
            end else begin
               // resync on a repeated first header byte
               idx_in = (rx_byte == HDR_FIRST) ? IW'(1) : IW'(0);
            end
         end else if (idx_ff == IW'(2)) begin
            len_in = rx_byte;
            if (rx_byte == 8'd0 ||
                (10'(rx_byte) + 10'(HDR_BYTES)) > 10'(MAX_FRAME_LEN)) begin
               idx_in = IW'(0);
            end else begin
               idx_in = IW'(HDR_BYTES);
            end
         end else begin
            if (idx_ff == IW'(POS_CMD))     cmd_in        = rx_byte;
            if (idx_ff == IW'(POS_ADDR_HI)) addr_in[15:8] = rx_byte;
            if (idx_ff == IW'(POS_ADDR_LO)) addr_in[7:0]  = rx_byte;
            if (idx_ff == IW'(POS_NWORDS))  nw_in         = rx_byte;
            if (idx_ff == IW'(POS_KEY_HI))  key_in[15:8]  = rx_byte;
            if (idx_ff == IW'(POS_KEY_LO))  key_in[7:0]   = rx_byte;
            if (idx_ff == IW'(POS_MINS_HI)) mins_in[15:8] = rx_byte;
            if (idx_ff == IW'(POS_MINS_LO)) mins_in[7:0]  = rx_byte;
            if (idx_next_w >= 10'(len_ff) + 10'(HDR_BYTES)) begin
               frame_done = 1'b1;
               idx_in     = IW'(0);
            end else begin
               idx_in = idx_next_w[IW-1:0];
            end
         end
      end
   end

   // read reply with at least address, word count and one key word
   assign decodable = (cmd_in == CMD_READ_REPLY) && (len_ff >= MIN_KEY_LEN) &&
                      (nw_in != 8'd0);

   assign rec_push       = frame_done && decodable;
   assign rec.addr       = addr_in;
   assign rec.key        = key_in;
   assign rec.mins       = mins_in;
   assign rec.two_words  = (nw_in >= 8'd2) && (len_ff >= MIN_TWO_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         len_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
      nw_ff   <= nw_in;
      key_ff  <= key_in;
      mins_ff <= mins_in;
   end

endmodule

/* sv/htfp_back.sv */
// event stage: address registers, priority match, one event word per cycle
// while the result queue has room; depends on htfp_pkg

module htfp_back (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [htfp_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [htfp_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic                                    rec_valid,
   input  htfp_pkg::frame_rec_type                 rec,
   output logic                                    rec_pop,
   input  logic                                    ev_full,
   output logic                                    ev_push,
   output htfp_pkg::event_type                     ev
);
   import htfp_pkg::*;

   logic [CSR_DATA_W-1:0] cfg_ff [CSR_COUNT];
   logic                  phase_ff, phase_in;
   logic                  hit_button, hit_time, hit_login, hit_any, send_mins;

   always_comb begin
      hit_button = (rec.addr == cfg_ff[CSR_BUTTON_KEY]) && (rec.key != 16'd0);
      hit_time   = !hit_button && ((rec.addr == cfg_ff[CSR_HOURS]) ||
                                   (rec.addr == cfg_ff[CSR_MINUTES]));
      hit_login  = !hit_button && !hit_time && (rec.key != 16'd0) &&
                   ((rec.addr == cfg_ff[CSR_SET_LOGIN]) ||
                    (rec.addr == cfg_ff[CSR_TIME_MODE]) ||
                    (rec.addr == cfg_ff[CSR_LOGIN]) ||
                    (rec.addr == cfg_ff[CSR_PRECHARGE]) ||
                    (rec.addr == cfg_ff[CSR_APPLY]));
      hit_any    = hit_button || hit_time || hit_login;
      send_mins  = hit_time && (rec.addr == cfg_ff[CSR_HOURS]) && rec.two_words;
   end

   always_comb begin
      phase_in = phase_ff;
      rec_pop  = 1'b0;
      ev_push  = 1'b0;
      ev.kind  = hit_button ? EV_BUTTON : EV_KEY;
      ev.addr  = rec.addr;
      ev.value = rec.key;
      ev.inval = !hit_time;
      ev.last  = !send_mins;
      if (phase_ff) begin
         // minutes word of an hours frame
         ev.kind  = EV_KEY;
         ev.addr  = cfg_ff[CSR_MINUTES];
         ev.value = rec.mins;
         ev.inval = 1'b0;
         ev.last  = 1'b1;
         if (!ev_full) begin
            ev_push  = 1'b1;
            rec_pop  = 1'b1;
            phase_in = 1'b0;
         end
      end else if (rec_valid) begin
         if (!hit_any) begin
            rec_pop = 1'b1;
         end else if (!ev_full) begin
            ev_push = 1'b1;
            if (send_mins) begin
               phase_in = 1'b1;
            end else begin
               rec_pop = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         for (int i = 0; i < CSR_COUNT; i++) begin
            cfg_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         if (csr_wr_en) begin
            cfg_ff[csr_index] <= csr_wdata;
         end
      end
   end

endmodule
